FILE: hdl/rcagg_pkg.sv
// Package: constants, request types and helpers for the rank aggregation core.
`timescale 1ns / 1ps
`default_nettype none
package rcagg_pkg;
	localparam int MAX_ITEMS = 64;
	localparam int FRAC_BITS = 16;
	localparam int IDX_W = $clog2(MAX_ITEMS);
	localparam int CNT_W = 7;
	localparam int NUM_W = 33;
	localparam int DIV_W = NUM_W + FRAC_BITS;
	localparam int DCNT_W = $clog2(DIV_W + 1);
	localparam int PADDR_W = 5;

	localparam logic [2:0] AGG_BORDA = 3'd0;
	localparam logic [2:0] AGG_RANK = 3'd1;
	localparam logic [2:0] AGG_MINMAX = 3'd2;
	localparam logic [2:0] AGG_ZSCORE = 3'd3;
	localparam logic [2:0] AGG_SIMPLE = 3'd4;

	localparam logic [1:0] WN_NONE = 2'd0;
	localparam logic [1:0] WN_MINMAX = 2'd1;
	localparam logic [1:0] WN_STD = 2'd2;
	localparam logic [1:0] WN_MAX = 2'd3;

	localparam logic [2:0] REG_AGG_MODE = 3'd0;
	localparam logic [2:0] REG_WN_MODE = 3'd1;
	localparam logic [2:0] REG_ITEM_COUNT = 3'd2;
	localparam logic [2:0] REG_WEIGHT_MIN = 3'd3;
	localparam logic [2:0] REG_WEIGHT_MAX = 3'd4;
	localparam logic [2:0] REG_WEIGHT_STD = 3'd5;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic        operation;
		logic [5:0]  item_index;
		logic        ranked;
		logic [15:0] rank;
		logic [15:0] list_length;
		logic [31:0] item_score;
		logic [31:0] list_min_score;
		logic [31:0] list_max_score;
		logic [31:0] list_mean_score;
		logic [31:0] list_std_score;
		logic [31:0] vote_wt;
	} in_req_t;

	typedef struct packed {
		logic [5:0]  out_index;
		logic [31:0] total_score;
		logic        last;
	} out_req_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [NUM_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quo;
	} div_rsp_t;

	function automatic logic [NUM_W-1:0] sx33(input logic [31:0] v);
		return {v[31], v};
	endfunction

	function automatic logic [NUM_W-1:0] sub33(input logic [31:0] a, input logic [31:0] b);
		return sx33(a) - sx33(b);
	endfunction
endpackage
`default_nettype wire

FILE: hdl/rcagg_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rcagg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule
`default_nettype wire

FILE: hdl/rcagg_div.sv
// Iterative restoring divider: saturated fixed-point quotient, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rcagg_div import rcagg_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);
	logic              busy_q;
	logic              neg_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [NUM_W-1:0]  dvs_q;
	logic [NUM_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dvd_q;
	logic              done_q;
	logic [31:0]       quo_q;

	logic [NUM_W-1:0] num_mag;
	logic [NUM_W-1:0] den_mag;
	logic [NUM_W:0]   rem_n;
	logic             fits;
	logic [DIV_W-1:0] dvd_n;
	logic [31:0]      sat_q;

	always_comb begin
		num_mag = req.num[NUM_W-1] ? (~req.num + 1'b1) : req.num;
		den_mag = req.den[NUM_W-1] ? (~req.den + 1'b1) : req.den;
		rem_n = {rem_q, dvd_q[DIV_W-1]};
		fits = rem_n >= {1'b0, dvs_q};
		dvd_n = {dvd_q[DIV_W-2:0], fits};
		if (!neg_q) begin
			sat_q = (|dvd_n[DIV_W-1:31]) ? S32_MAX : dvd_n[31:0];
		end else if ((|dvd_n[DIV_W-1:32]) || (dvd_n[31] && (|dvd_n[30:0]))) begin
			sat_q = S32_MIN;
		end else begin
			sat_q = ~dvd_n[31:0] + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (req.den == '0) begin
					done_q <= 1'b1;
					if (req.num == '0) begin
						quo_q <= '0;
					end else begin
						quo_q <= req.num[NUM_W-1] ? S32_MIN : S32_MAX;
					end
				end else begin
					busy_q <= 1'b1;
					cnt_q <= DCNT_W'(DIV_W - 1);
					neg_q <= req.num[NUM_W-1] ^ req.den[NUM_W-1];
					dvs_q <= den_mag;
					rem_q <= '0;
					dvd_q <= {num_mag, {FRAC_BITS{1'b0}}};
				end
			end else if (busy_q) begin
				rem_q <= fits ? NUM_W'(rem_n - {1'b0, dvs_q}) : rem_n[NUM_W-1:0];
				dvd_q <= dvd_n;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					quo_q <= sat_q;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = quo_q;

	assert property (@(posedge clk) disable iff (!arst_n) req.start |-> !busy_q)
		else $error("divider started while busy");
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q)
		else $error("divider done while still busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q != '0) |=> busy_q)
		else $error("divider stopped early");
endmodule
`default_nettype wire

FILE: hdl/combsum_rank_aggregation_core.sv
// Top level: CombSUM rank aggregation core with sequencer, multiplier and score table.
// Usage:
//   Input channel (in_valid/in_stall/in_data) takes one request at a time: an add
//   contribution or a finish. in_stall is high whenever the sequencer is busy.
//   For an add request, each fixed-point division runs on a shared bit-serial
//   divider at one quotient bit per cycle, and a request needs up to two
//   divisions plus up to three products on the shared 32x32 multiplier, then
//   a read-modify-write of the score table RAM.
//   Out-of-range item indexes are dropped.
//   A finish request emits min(item_count, 64) results on out_valid/out_stall in
//   descending score order (ties by lower index), last set on the final one.
//   Each result is found by a selection scan of the table, which reads and then
//   compares each entry in turn.
//   After the final result the table is cleared at once through per-entry valid bits.
//   A stalled result holds its payload until taken; the scan waits meanwhile.
//   Reset clears the table and loads the register defaults; no clearing pass.
//   Registers are written over the APB port at byte address 4*index.
`timescale 1ns / 1ps
`default_nettype none
module combsum_rank_aggregation_core import rcagg_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire in_req_t            in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output out_req_t                out_data,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_W = 4'd1;
	localparam logic [3:0] S_WM1 = 4'd2;
	localparam logic [3:0] S_WM2 = 4'd3;
	localparam logic [3:0] S_WM3 = 4'd4;
	localparam logic [3:0] S_WDIV = 4'd5;
	localparam logic [3:0] S_SC = 4'd6;
	localparam logic [3:0] S_SDIV = 4'd7;
	localparam logic [3:0] S_FM = 4'd8;
	localparam logic [3:0] S_ACC = 4'd9;
	localparam logic [3:0] S_SCAN_RD = 4'd10;
	localparam logic [3:0] S_SCAN_CMP = 4'd11;
	localparam logic [3:0] S_EMIT = 4'd12;

	logic [2:0]  agg_mode_q;
	logic [1:0]  wn_mode_q;
	logic [6:0]  item_count_q;
	logic [31:0] weight_min_q;
	logic [31:0] weight_max_q;
	logic [31:0] weight_std_q;

	logic [3:0]           state_q;
	in_req_t              req_q;
	logic [31:0]          w_q;
	logic [31:0]          score_q;
	logic [31:0]          mul_q;
	logic [MAX_ITEMS-1:0] vld_q;
	logic [MAX_ITEMS-1:0] done_q;
	logic [CNT_W-1:0]     k_q;
	logic [CNT_W-1:0]     j_q;
	logic                 found_q;
	logic [31:0]          best_val_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic                 out_valid_q;
	out_req_t             out_data_q;

	logic [CNT_W-1:0] size;
	logic             wr_cfg;
	div_req_t         div_req;
	div_rsp_t         div_rsp;
	logic [31:0]      mul_a;
	logic [31:0]      mul_b;
	logic [63:0]      prod;
	logic [63:0]      prod_sh;
	logic [31:0]      prod_sat;
	logic [IDX_W-1:0] rd_addr;
	logic [31:0]      rd_data;
	logic [31:0]      entry;
	logic [32:0]      acc_sum;
	logic [31:0]      acc_sat;
	logic             ram_we;
	logic [IDX_W-1:0] scan_idx;
	logic             score_div;
	logic [6:0]       n_ext;

	assign size = (item_count_q < CNT_W'(MAX_ITEMS)) ? item_count_q : CNT_W'(MAX_ITEMS);
	assign in_stall = (state_q != S_IDLE);
	assign pready = 1'b1;
	assign wr_cfg = psel && penable && pwrite;
	assign n_ext = item_count_q;
	assign scan_idx = j_q[IDX_W-1:0];

	always_comb begin
		case (paddr[4:2])
			REG_AGG_MODE:   prdata = {29'd0, agg_mode_q};
			REG_WN_MODE:    prdata = {30'd0, wn_mode_q};
			REG_ITEM_COUNT: prdata = {25'd0, item_count_q};
			REG_WEIGHT_MIN: prdata = weight_min_q;
			REG_WEIGHT_MAX: prdata = weight_max_q;
			REG_WEIGHT_STD: prdata = weight_std_q;
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			agg_mode_q <= AGG_BORDA;
			wn_mode_q <= WN_NONE;
			item_count_q <= 7'd1;
			weight_min_q <= '0;
			weight_max_q <= 32'(1 << FRAC_BITS);
			weight_std_q <= 32'(1 << FRAC_BITS);
		end else if (wr_cfg) begin
			case (paddr[4:2])
				REG_AGG_MODE:   agg_mode_q <= pwdata[2:0];
				REG_WN_MODE:    wn_mode_q <= pwdata[1:0];
				REG_ITEM_COUNT: item_count_q <= pwdata[6:0];
				REG_WEIGHT_MIN: weight_min_q <= pwdata;
				REG_WEIGHT_MAX: weight_max_q <= pwdata;
				REG_WEIGHT_STD: weight_std_q <= pwdata;
				default:        ;
			endcase
		end
	end

	// shared multiplier: floor(a*b / 2^FRAC), saturated
	always_comb begin
		case (state_q)
			S_WM2:   begin mul_a = mul_q; mul_b = weight_std_q; end
			S_FM:    begin mul_a = score_q; mul_b = w_q; end
			default: begin mul_a = req_q.vote_wt; mul_b = weight_std_q; end
		endcase
		prod = $signed(mul_a) * $signed(mul_b);
		prod_sh = $signed(prod) >>> FRAC_BITS;
		if ((&prod_sh[63:31]) || !(|prod_sh[63:31])) begin
			prod_sat = prod_sh[31:0];
		end else begin
			prod_sat = prod_sh[63] ? S32_MIN : S32_MAX;
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= prod_sat;
	end

	// divider requests
	always_comb begin
		score_div = req_q.ranked ? (agg_mode_q <= AGG_SIMPLE) : (agg_mode_q == AGG_BORDA);
		div_req.start = 1'b0;
		div_req.num = '0;
		div_req.den = '0;
		case (state_q)
			S_W: begin
				div_req.start = (wn_mode_q == WN_MINMAX) || (wn_mode_q == WN_MAX);
				if (wn_mode_q == WN_MINMAX) begin
					div_req.num = sub33(req_q.vote_wt, weight_min_q);
					div_req.den = sub33(weight_max_q, weight_min_q);
				end else begin
					div_req.num = sx33(req_q.vote_wt);
					div_req.den = sx33(weight_max_q);
				end
			end
			S_WM3: begin
				div_req.start = 1'b1;
				div_req.num = sx33(mul_q);
				div_req.den = sx33(weight_max_q);
			end
			S_SC: begin
				div_req.start = score_div;
				if (!req_q.ranked) begin
					div_req.num = {26'd0, n_ext} - {17'd0, req_q.list_length} + 33'd1;
					div_req.den = {25'd0, n_ext, 1'b0};
				end else begin
					case (agg_mode_q)
						AGG_RANK: begin
							div_req.num = {17'd0, req_q.list_length} - {17'd0, req_q.rank} + 33'd1;
							div_req.den = {17'd0, req_q.list_length};
						end
						AGG_MINMAX: begin
							div_req.num = sub33(req_q.item_score, req_q.list_min_score);
							div_req.den = sub33(req_q.list_max_score, req_q.list_min_score);
						end
						AGG_ZSCORE: begin
							div_req.num = sub33(req_q.item_score, req_q.list_mean_score);
							div_req.den = sx33(req_q.list_std_score);
						end
						default: begin
							div_req.num = {26'd0, n_ext} - {17'd0, req_q.rank} + 33'd1;
							div_req.den = {26'd0, n_ext};
						end
					endcase
				end
			end
			default: ;
		endcase
	end

	rcagg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign rd_addr = (state_q == S_SCAN_RD || state_q == S_SCAN_CMP) ? scan_idx
		: req_q.item_index;
	assign entry = vld_q[rd_addr] ? rd_data : '0;
	assign acc_sum = {entry[31], entry} + {mul_q[31], mul_q};
	assign acc_sat = (acc_sum[32] == acc_sum[31]) ? acc_sum[31:0]
		: (acc_sum[32] ? S32_MIN : S32_MAX);
	assign ram_we = (state_q == S_ACC);

	rcagg_ram #(.WIDTH(32), .DEPTH(MAX_ITEMS)) u_table (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (req_q.item_index),
		.wr_data (acc_sat),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vld_q <= '0;
			done_q <= '0;
			out_valid_q <= 1'b0;
			k_q <= '0;
			j_q <= '0;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q <= in_data;
						if (in_data.operation == OP_FINISH) begin
							k_q <= '0;
							j_q <= '0;
							found_q <= 1'b0;
							if (size == '0) begin
								vld_q <= '0;
								done_q <= '0;
							end else begin
								state_q <= S_SCAN_RD;
							end
						end else if (CNT_W'(in_data.item_index) < size) begin
							state_q <= S_W;
						end
					end
				end
				S_W: begin
					case (wn_mode_q)
						WN_NONE: begin
							w_q <= req_q.vote_wt;
							state_q <= S_SC;
						end
						WN_STD:  state_q <= S_WM1;
						default: state_q <= S_WDIV;
					endcase
				end
				S_WM1: state_q <= S_WM2;
				S_WM2: state_q <= S_WM3;
				S_WM3: state_q <= S_WDIV;
				S_WDIV: begin
					if (div_rsp.done) begin
						w_q <= div_rsp.quo;
						state_q <= S_SC;
					end
				end
				S_SC: begin
					if (score_div) begin
						state_q <= S_SDIV;
					end else begin
						score_q <= '0;
						state_q <= S_FM;
					end
				end
				S_SDIV: begin
					if (div_rsp.done) begin
						score_q <= div_rsp.quo;
						state_q <= S_FM;
					end
				end
				S_FM: state_q <= S_ACC;
				S_ACC: begin
					vld_q[req_q.item_index] <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SCAN_RD: begin
					if (j_q == size) begin
						out_valid_q <= 1'b1;
						out_data_q.out_index <= best_idx_q;
						out_data_q.total_score <= best_val_q;
						out_data_q.last <= (k_q + 1'b1 == size);
						state_q <= S_EMIT;
					end else begin
						state_q <= S_SCAN_CMP;
					end
				end
				S_SCAN_CMP: begin
					if (!done_q[scan_idx] && (!found_q || $signed(entry) > $signed(best_val_q))) begin
						found_q <= 1'b1;
						best_val_q <= entry;
						best_idx_q <= scan_idx;
					end
					j_q <= j_q + 1'b1;
					state_q <= S_SCAN_RD;
				end
				S_EMIT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						k_q <= k_q + 1'b1;
						j_q <= '0;
						found_q <= 1'b0;
						if (k_q + 1'b1 == size) begin
							vld_q <= '0;
							done_q <= '0;
							state_q <= S_IDLE;
						end else begin
							done_q[best_idx_q] <= 1'b1;
							state_q <= S_SCAN_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	assert property (@(posedge clk) disable iff (!arst_n) out_valid_q |-> (state_q == S_EMIT))
		else $error("result shown outside emit");
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (CNT_W'(req_q.item_index) < size))
		else $error("table write out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_WDIV || state_q == S_SDIV))
		else $error("divider result with no waiting state");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && !out_stall && out_data_q.last) |=> (vld_q == '0))
		else $error("table not cleared after finish");
endmodule
`default_nettype wire

FILE: dv/combsum_rank_aggregation_core_tb.sv
// Testbench: directed table and random phases for the CombSUM rank aggregation core.
`timescale 1ns / 1ps
`default_nettype none
module combsum_rank_aggregation_core_tb;
	import rcagg_pkg::*;

	localparam logic [2:0] AGG_UNUSED = 3'd7;
	localparam int STALL_LIMIT = 40000;
	localparam int ADD_LATENCY = 130;

	typedef struct {
		bit          is_cfg;
		logic [2:0]  reg_idx;
		logic [31:0] value;
		in_req_t     req;
		bit          has_exp;
		out_req_t    exp;
	} step_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	in_req_t            in_data;
	logic               out_valid;
	logic               out_stall;
	out_req_t           out_data;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	// predictor state
	logic [2:0]         agg_mode;
	logic [1:0]         wn_mode;
	logic [6:0]         n_items;
	logic signed [31:0] w_min;
	logic signed [31:0] w_max;
	logic signed [31:0] w_std;
	logic signed [31:0] score_model [MAX_ITEMS];

	out_req_t           ranked_q [$];
	step_t              steps [$];
	bit                 idle_on;
	int                 errors;
	int                 n_requests;
	int                 n_results;
	int                 n_finish;
	int                 quiet_cycles;

	combsum_rank_aggregation_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic logic signed [31:0] sat32(longint v);
		if (v > longint'(S32_MAX)) return S32_MAX;
		if (v < longint'(S32_MIN)) return S32_MIN;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] fx_quot(longint num, longint den);
		if (den == 0) begin
			if (num > 0) return S32_MAX;
			if (num < 0) return S32_MIN;
			return 0;
		end
		return sat32((num * (longint'(1) << FRAC_BITS)) / den);
	endfunction

	function automatic logic signed [31:0] fx_prod(logic signed [31:0] a,
			logic signed [31:0] b);
		longint p;
		p = longint'(a) * longint'(b);
		return sat32(p >>> FRAC_BITS);
	endfunction

	function automatic logic signed [31:0] weight_of(logic signed [31:0] w);
		case (wn_mode)
			WN_MINMAX: return fx_quot(longint'(w) - w_min, longint'(w_max) - w_min);
			WN_STD:    return fx_quot(fx_prod(fx_prod(w, w_std), w_std), w_max);
			WN_MAX:    return fx_quot(w, w_max);
			default:   return w;
		endcase
	endfunction

	function automatic int table_len();
		return (n_items < MAX_ITEMS) ? n_items : MAX_ITEMS;
	endfunction

	function automatic void apply_reg(logic [2:0] idx, logic [31:0] v);
		case (idx)
			REG_AGG_MODE:   agg_mode = v[2:0];
			REG_WN_MODE:    wn_mode = v[1:0];
			REG_ITEM_COUNT: n_items = v[6:0];
			REG_WEIGHT_MIN: w_min = v;
			REG_WEIGHT_MAX: w_max = v;
			REG_WEIGHT_STD: w_std = v;
			default: ;
		endcase
	endfunction

	function automatic void fuse_contribution(in_req_t r);
		logic signed [31:0] w;
		logic signed [31:0] s;
		longint n;
		longint rk;
		longint len;
		w = weight_of(r.vote_wt);
		s = 0;
		n = n_items;
		rk = r.rank;
		len = r.list_length;
		if (r.item_index >= table_len()) return;
		if (r.ranked) begin
			case (agg_mode)
				AGG_BORDA, AGG_SIMPLE: s = fx_quot(n - rk + 1, n);
				AGG_RANK:   s = fx_quot(len - rk + 1, len);
				AGG_MINMAX: s = fx_quot(longint'($signed(r.item_score)) - $signed(r.list_min_score),
					longint'($signed(r.list_max_score)) - $signed(r.list_min_score));
				AGG_ZSCORE: s = fx_quot(longint'($signed(r.item_score)) -
					$signed(r.list_mean_score), longint'($signed(r.list_std_score)));
				default: s = 0;
			endcase
		end else if (agg_mode == AGG_BORDA) begin
			s = fx_quot(n - len + 1, 2 * n);
		end
		s = fx_prod(s, w);
		score_model[r.item_index] = sat32(longint'(score_model[r.item_index]) + s);
	endfunction

	// selection by highest score, lowest index on ties
	function automatic void emit_ranking();
		bit taken [MAX_ITEMS];
		int sz;
		int best;
		out_req_t o;
		sz = table_len();
		foreach (taken[i]) taken[i] = 0;
		for (int k = 0; k < sz; k++) begin
			best = -1;
			for (int i = 0; i < sz; i++)
				if (!taken[i] && (best < 0 || score_model[i] > score_model[best])) best = i;
			taken[best] = 1;
			o.out_index = best[5:0];
			o.total_score = score_model[best];
			o.last = (k + 1 == sz);
			ranked_q.push_back(o);
		end
		foreach (score_model[i]) score_model[i] = 0;
	endfunction

	function automatic in_req_t add_req(int idx, bit rk_on, int rk, int len,
			logic [31:0] sc, logic [31:0] smin, logic [31:0] smax,
			logic [31:0] smean, logic [31:0] sstd, logic [31:0] w);
		in_req_t r;
		r.operation = OP_ADD;
		r.item_index = idx[5:0];
		r.ranked = rk_on;
		r.rank = rk[15:0];
		r.list_length = len[15:0];
		r.item_score = sc;
		r.list_min_score = smin;
		r.list_max_score = smax;
		r.list_mean_score = smean;
		r.list_std_score = sstd;
		r.vote_wt = w;
		return r;
	endfunction

	function automatic in_req_t fin_req();
		logic [255:0] raw;
		in_req_t r;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom};
		r = raw[$bits(in_req_t)-1:0];
		r.operation = OP_FINISH;
		return r;
	endfunction

	function automatic void row_cfg(logic [2:0] idx, logic [31:0] v);
		step_t s;
		s = '{default: 0};
		s.is_cfg = 1;
		s.reg_idx = idx;
		s.value = v;
		steps.push_back(s);
	endfunction

	function automatic void row_req(in_req_t r, bit has_exp = 0, out_req_t e = '0);
		step_t s;
		s = '{default: 0};
		s.req = r;
		s.has_exp = has_exp;
		s.exp = e;
		steps.push_back(s);
	endfunction

	function automatic logic [31:0] rnd_q();
		case ($urandom_range(6))
			0: return S32_MIN;
			1: return S32_MAX;
			2: return 0;
			3, 4: return $urandom;
			default: return $urandom_range(0, 32'h0006_0000) - 32'h0002_0000;
		endcase
	endfunction

	task automatic send(in_req_t r, bit has_exp = 0, out_req_t e = '0);
		while (idle_on && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		do @(posedge clk); while (in_stall);
		n_requests++;
		if (r.operation == OP_FINISH) begin
			n_finish++;
			if (has_exp) begin
				foreach (score_model[i]) score_model[i] = 0;
				ranked_q.push_back(e);
			end else begin
				emit_ranking();
			end
		end else begin
			fuse_contribution(r);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		wait (ranked_q.size() == 0);
		repeat (ADD_LATENCY) @(posedge clk);
	endtask

	task automatic set_reg(logic [2:0] idx, logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(idx) << 2;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		apply_reg(idx, v);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		out_stall <= idle_on && ($urandom_range(99) < 26);
		if (out_valid && !out_stall) begin
			n_results++;
			if (ranked_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result idx=%0d score=%h last=%b", $time,
					out_data.out_index, out_data.total_score, out_data.last);
			end else begin
				if (out_data !== ranked_q[0]) begin
					errors++;
					$display("%0t: mismatch expected idx=%0d score=%h last=%b,",
						$time, ranked_q[0].out_index, ranked_q[0].total_score,
						ranked_q[0].last);
					$display("    got idx=%0d score=%h last=%b",
						out_data.out_index, out_data.total_score, out_data.last);
				end
				void'(ranked_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress, %0d results still expected", $time, ranked_q.size());
			$display("combsum_rank_aggregation_core_tb: FAIL");
			$finish;
		end
	end

	initial begin
		int cnt;
		int len;
		in_req_t r;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_on = 1;
		errors = 0;
		n_requests = 0;
		n_results = 0;
		n_finish = 0;
		quiet_cycles = 0;
		agg_mode = AGG_BORDA;
		wn_mode = WN_NONE;
		n_items = 1;
		w_min = 0;
		w_max = 32'h0001_0000;
		w_std = 32'h0001_0000;
		foreach (score_model[i]) score_model[i] = 0;

		row_req(fin_req(), 1, '{out_index: 0, total_score: 0, last: 1});
		row_req(add_req(0, 1, 1, 0, 0, 0, 0, 0, 0, 32'h0001_0000));
		row_req(fin_req(), 1, '{out_index: 0, total_score: 32'h0001_0000, last: 1});
		row_cfg(REG_ITEM_COUNT, 4);
		row_cfg(REG_AGG_MODE, AGG_ZSCORE);
		row_req(add_req(1, 1, 0, 0, S32_MAX, 0, 0, S32_MIN, 0, S32_MAX));
		row_req(add_req(2, 1, 0, 0, S32_MIN, 0, 0, S32_MAX, 0, 32'h0001_0000));
		row_req(add_req(3, 1, 0, 0, 5, 0, 0, 5, 0, 32'h0001_0000));
		row_req(add_req(63, 1, 0, 0, 32'h0004_0000, 0, 0, 0, 32'h0001_0000, S32_MAX));
		row_req(add_req(1, 1, 0, 0, S32_MAX, 0, 0, S32_MIN, 0, S32_MAX));
		row_req(fin_req());
		row_cfg(REG_AGG_MODE, AGG_MINMAX);
		row_cfg(REG_WN_MODE, WN_MINMAX);
		row_cfg(REG_WEIGHT_MIN, S32_MIN);
		row_cfg(REG_WEIGHT_MAX, S32_MAX);
		row_req(add_req(0, 1, 0, 0, 32'h0003_0000, 0, 32'h0008_0000, 0, 0, 0));
		row_req(add_req(3, 1, 0, 0, 32'h0001_0000, 7, 7, 0, 0, S32_MAX));
		row_cfg(REG_AGG_MODE, AGG_RANK);
		row_req(add_req(2, 1, 0, 0, 0, 0, 0, 0, 0, 32'h0001_0000));
		row_req(add_req(1, 1, 65535, 65535, 0, 0, 0, 0, 0, S32_MAX));
		row_cfg(REG_AGG_MODE, AGG_BORDA);
		row_cfg(REG_WN_MODE, WN_STD);
		row_cfg(REG_WEIGHT_STD, S32_MAX);
		row_req(add_req(0, 0, 0, 65535, 0, 0, 0, 0, 0, 32'h0000_0100));
		row_req(add_req(1, 0, 0, 0, 0, 0, 0, 0, 0, S32_MIN));
		row_cfg(REG_WN_MODE, WN_MAX);
		row_cfg(REG_WEIGHT_MAX, 0);
		row_req(add_req(2, 1, 65535, 0, 0, 0, 0, 0, 0, 32'h0002_0000));
		row_cfg(REG_AGG_MODE, AGG_SIMPLE);
		row_cfg(REG_WEIGHT_MAX, 32'h0001_0000);
		row_req(add_req(3, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0001_0000));
		row_req(add_req(3, 1, 2, 0, 0, 0, 0, 0, 0, 32'h0001_0000));
		row_cfg(REG_AGG_MODE, AGG_UNUSED);
		row_req(add_req(0, 1, 1, 1, 0, 0, 0, 0, 0, 32'h0001_0000));
		row_req(fin_req());
		row_cfg(REG_ITEM_COUNT, 0);
		row_req(fin_req());
		row_cfg(REG_ITEM_COUNT, 127);
		row_cfg(REG_AGG_MODE, AGG_BORDA);
		row_cfg(REG_WN_MODE, WN_NONE);
		row_req(add_req(63, 1, 3, 9, 0, 0, 0, 0, 0, 32'h0001_0000));
		row_req(fin_req());

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steps[i]) begin
			if (steps[i].is_cfg) begin
				drain();
				set_reg(steps[i].reg_idx, steps[i].value);
			end else begin
				send(steps[i].req, steps[i].has_exp, steps[i].exp);
			end
		end

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			idle_on = (ph != 2);
			cnt = (ph == 5) ? 64 : $urandom_range(1, 8);
			set_reg(REG_ITEM_COUNT, cnt);
			set_reg(REG_AGG_MODE, ($urandom_range(9) == 0) ? AGG_UNUSED : $urandom_range(0, 4));
			set_reg(REG_WN_MODE, $urandom_range(0, 3));
			set_reg(REG_WEIGHT_MIN, ($urandom_range(3) == 0) ? rnd_q() : 0);
			set_reg(REG_WEIGHT_MAX, ($urandom_range(3) == 0) ? rnd_q() :
				$urandom_range(32'h0000_8000, 32'h0004_0000));
			set_reg(REG_WEIGHT_STD, ($urandom_range(3) == 0) ? rnd_q() :
				$urandom_range(32'h0000_4000, 32'h0002_0000));
			for (int k = 0; k < 22; k++) begin
				if ($urandom_range(99) < 10) begin
					send(fin_req());
				end else begin
					len = ($urandom_range(7) == 0) ? $urandom_range(0, 65535) :
						$urandom_range(0, 2 * cnt);
					r = add_req(($urandom_range(9) == 0) ? $urandom_range(0, 63) :
							$urandom_range(0, cnt - 1),
						$urandom_range(99) < 80,
						($urandom_range(7) == 0) ? $urandom_range(0, 65535) :
							$urandom_range(0, len + 1),
						len, rnd_q(), rnd_q(), rnd_q(), rnd_q(), rnd_q(),
						($urandom_range(3) == 0) ? rnd_q() :
							$urandom_range(0, 32'h0002_0000));
					send(r);
				end
			end
			send(fin_req());
		end
		in_valid <= 1'b0;
		wait (ranked_q.size() == 0);
		repeat (ADD_LATENCY) @(posedge clk);

		$display("Covered %0d requests (%0d finish runs) and %0d ranked results,",
			n_requests, n_finish, n_results);
		$display("across all aggregation and weight modes with saturation cases.");
		if (errors == 0)
			$display("combsum_rank_aggregation_core_tb: PASS");
		else
			$display("combsum_rank_aggregation_core_tb: FAIL");
		$finish;
	end
endmodule
`default_nettype wire

FILE: sim.f
hdl/rcagg_pkg.sv
hdl/rcagg_ram.sv
hdl/rcagg_div.sv
hdl/combsum_rank_aggregation_core.sv
dv/combsum_rank_aggregation_core_tb.sv
